>>> src/mf3_pkg.sv
package mf3_pkg;

   localparam int FRAME_WIDTH  = 384;
   localparam int FRAME_HEIGHT = 288;

   localparam int PIX_W   = 16;
   localparam int COORD_W = 9;
   localparam int COL_W   = $clog2(FRAME_WIDTH);
   localparam int ROW_W   = $clog2(FRAME_HEIGHT);

   // width used to form centre coordinates before masking to COORD_W
   localparam int CCOL_W  = (COL_W > COORD_W) ? COL_W : COORD_W;
   localparam int CROW_W  = (ROW_W > COORD_W) ? ROW_W : COORD_W;

   // pipeline stages between acceptance and the output queue
   localparam int PIPE_STAGES = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   typedef logic signed [PIX_W-1:0] pixel_type;
   typedef logic [COORD_W-1:0]      coord_type;
   typedef logic [COL_W-1:0]        col_type;
   typedef logic [ROW_W-1:0]        row_type;

   // one line store entry: row r-2 and row r-1 at the same column
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_word_type;

   typedef struct packed {
      logic      result;
      coord_type col;
      coord_type row;
      logic      frame_end;
   } meta_type;

   typedef struct packed {
      pixel_type median_value;
      coord_type center_col;
      coord_type center_row;
      logic      frame_end;
   } result_type;

   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } col_sort_type;

   function automatic pixel_type pix_min(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type pix_max(input pixel_type a, input pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pixel_type median3(input pixel_type a, input pixel_type b,
                                         input pixel_type c);
      return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
   endfunction

   function automatic col_sort_type sort3(input pixel_type a, input pixel_type b,
                                          input pixel_type c);
      pixel_type    lo_ab;
      pixel_type    hi_ab;
      pixel_type    x;
      col_sort_type s;
      lo_ab = pix_min(a, b);
      hi_ab = pix_max(a, b);
      x     = pix_min(hi_ab, c);
      s.hi  = pix_max(hi_ab, c);
      s.lo  = pix_min(lo_ab, x);
      s.md  = pix_max(lo_ab, x);
      return s;
   endfunction

endpackage

>>> src/median_filter_3x3.sv
// 3x3 median filter over a raster-order frame of FRAME_WIDTH x FRAME_HEIGHT
// signed 16-bit pixels.
// req channel: one pixel per transaction (req_valid/req_ready/req_pixel),
// starting at column 0, row 0 after reset; frames follow each other directly.
// rsp channel: one result per interior pixel (column and row both between 1
// and size-2): the signed median of its 3x3 neighbourhood, its column and
// row, and rsp_frame_end on the last interior result of the frame. Border
// pixels give no result.
// Throughput: one pixel per cycle while the queue has room, set by the single line store RAM, which
// is read in the accept cycle and written back the next cycle.
// Pipeline: a result passes the accept registers and the window's column and
// merge registers, then waits in an 8-entry output queue.
// When the receiver stalls, req_ready drops once the queue can no longer
// absorb the transactions still in the pipeline, and resumes as it drains.
// Reset clears the position counters, pipeline and queue; the line store
// needs no clearing since the first two rows of a frame fill it before use.
module median_filter_3x3
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [PIX_W-1:0]   req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PIX_W-1:0]   rsp_median_value,
   output logic [COORD_W-1:0]        rsp_center_col,
   output logic [COORD_W-1:0]        rsp_center_row,
   output logic                      rsp_frame_end
);

   logic          accept;
   col_type       col_ff;
   col_type       col_in;
   row_type       row_ff;
   row_type       row_in;
   logic          col_last;
   logic          row_last;
   logic [CCOL_W-1:0] ccol;
   logic [CROW_W-1:0] crow;
   meta_type      meta;

   logic          a_valid_ff;
   col_type       a_col_ff;
   pixel_type     a_pixel_ff;
   meta_type      a_meta_ff;

   line_word_type rd_data;
   line_word_type wr_data;

   logic          win_valid;
   result_type    win_result;
   result_type    rsp_result;
   logic          room;

   assign accept   = req_valid & req_ready;
   assign req_ready = room;

   assign col_last = (col_ff == COL_W'(FRAME_WIDTH - 1));
   assign row_last = (row_ff == ROW_W'(FRAME_HEIGHT - 1));

   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + 1'b1;
      end
   end

   always_comb begin
      ccol           = CCOL_W'(col_ff) - 1'b1;
      crow           = CROW_W'(row_ff) - 1'b1;
      meta.result    = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      meta.col       = ccol[COORD_W-1:0];
      meta.row       = crow[COORD_W-1:0];
      meta.frame_end = col_last & row_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
      if (accept) begin
         a_col_ff   <= col_ff;
         a_pixel_ff <= req_pixel;
         a_meta_ff  <= meta;
      end
   end

   // advance the column: middle row moves up, new pixel becomes middle
   assign wr_data.upper  = rd_data.middle;
   assign wr_data.middle = a_pixel_ff;

   mf3_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data (wr_data)
   );

   mf3_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid_ff),
      .in_upper   (rd_data.upper),
      .in_middle  (rd_data.middle),
      .in_pixel   (a_pixel_ff),
      .in_meta    (a_meta_ff),
      .out_valid  (win_valid),
      .out_result (win_result)
   );

   mf3_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (win_valid),
      .push_data (win_result),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_result),
      .room      (room)
   );

   assign rsp_median_value = rsp_result.median_value;
   assign rsp_center_col   = rsp_result.center_col;
   assign rsp_center_row   = rsp_result.center_row;
   assign rsp_frame_end    = rsp_result.frame_end;

endmodule

>>> src/mf3_line_store.sv
module mf3_line_store
   import mf3_pkg::*;
(
   input  logic          clock,
   input  logic          rd_en,
   input  col_type       rd_addr,
   output line_word_type rd_data,
   input  logic          wr_en,
   input  col_type       wr_addr,
   input  line_word_type wr_data
);

   line_word_type mem [FRAME_WIDTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mf3_window.sv
module mf3_window
   import mf3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  pixel_type  in_upper,
   input  pixel_type  in_middle,
   input  pixel_type  in_pixel,
   input  meta_type   in_meta,
   output logic       out_valid,
   output result_type out_result
);

   // sorted window columns, index 2 newest
   col_sort_type col_ff [3];
   col_sort_type col_in [3];
   logic         b_valid_ff;
   meta_type     b_meta_ff;

   pixel_type    lo_max_ff;
   pixel_type    md_med_ff;
   pixel_type    hi_min_ff;
   logic         c_valid_ff;
   meta_type     c_meta_ff;

   always_comb begin
      col_in[0] = col_ff[1];
      col_in[1] = col_ff[2];
      col_in[2] = sort3(in_upper, in_middle, in_pixel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
      end
      // shift window only on a real transaction
      if (in_valid) begin
         col_ff    <= col_in;
         b_meta_ff <= in_meta;
      end
      lo_max_ff <= pix_max(pix_max(col_ff[0].lo, col_ff[1].lo), col_ff[2].lo);
      md_med_ff <= median3(col_ff[0].md, col_ff[1].md, col_ff[2].md);
      hi_min_ff <= pix_min(pix_min(col_ff[0].hi, col_ff[1].hi), col_ff[2].hi);
      c_meta_ff <= b_meta_ff;
   end

   assign out_valid               = c_valid_ff & c_meta_ff.result;
   assign out_result.median_value = median3(lo_max_ff, md_med_ff, hi_min_ff);
   assign out_result.center_col   = c_meta_ff.col;
   assign out_result.center_row   = c_meta_ff.row;
   assign out_result.frame_end    = c_meta_ff.frame_end;

endmodule

>>> src/mf3_out_fifo.sv
module mf3_out_fifo
   import mf3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data,
   output logic       room
);

   result_type           buf_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff;
   logic [FIFO_AW:0]     count_in;
   logic                 pop;

   assign pop       = pop_valid & pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = buf_ff[rd_ptr_ff];

   // leave space for everything still in the pipeline plus one new transaction
   assign room = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - PIPE_STAGES - 1));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
